// ----- rtl/core/isaext_pkg.sv -----
package isaext_pkg;

   // extension table
   localparam int EXT_COUNT    = 19;
   localparam int EXT_NAME_MAX = 11;
   localparam int NAME_BUFFER_LEN_DEFAULT = 16;

   typedef logic [EXT_NAME_MAX*8-1:0] entry_text_type;
   typedef logic [EXT_COUNT-1:0]      ext_mask_type;

   // names sit right-justified: last character in the low byte
   localparam entry_text_type EXT_NAME [EXT_COUNT] = '{
      "i", "m", "a", "f", "d", "q", "c", "h",
      "zicntr", "zicsr", "zifencei", "zihintpause", "zihpm",
      "zba", "zbb", "zbs", "smaia", "ssaia", "svpbmt"
   };

   localparam logic [3:0] EXT_LEN [EXT_COUNT] = '{
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd6, 4'd5, 4'd8, 4'd11, 4'd5,
      4'd3, 4'd3, 4'd3, 4'd5, 4'd5, 4'd6
   };

   localparam int BIT_ZBA = 13;
   localparam int BIT_ZBB = 14;
   localparam int BIT_ZBS = 15;
   localparam ext_mask_type B_EXPAND_MASK =
      ext_mask_type'((1 << BIT_ZBA) | (1 << BIT_ZBB) | (1 << BIT_ZBS));

   // configuration
   localparam logic       WIDTH_IS_64_RESET   = 1'b1;
   localparam ext_mask_type REQUIRED_MASK_RESET = ext_mask_type'(282311);

   typedef enum logic {
      CSR_WIDTH_IS_64   = 1'b0,
      CSR_REQUIRED_MASK = 1'b1
   } csr_index_type;

   // result status
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_PREFIX = 2'd1,
      STATUS_ILLEGAL    = 2'd2
   } status_type;

   // characters
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_R          = "r";
   localparam logic [7:0] CH_V          = "v";
   localparam logic [7:0] CH_I          = "i";
   localparam logic [7:0] CH_P          = "p";
   localparam logic [7:0] CH_U          = "u";
   localparam logic [7:0] CH_X          = "x";
   localparam logic [7:0] CH_S          = "s";
   localparam logic [7:0] CH_Z          = "z";
   localparam logic [7:0] CH_B          = "b";
   localparam logic [7:0] CH_UNDERSCORE = "_";
   localparam logic [7:0] CH_3          = "3";
   localparam logic [7:0] CH_2          = "2";
   localparam logic [7:0] CH_6          = "6";
   localparam logic [7:0] CH_4          = "4";

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= "a") && (c <= "z");
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? 8'hFF : v + 8'd1;
   endfunction

   // character j of table entry k, counted from the front of the name
   function automatic logic [7:0] ext_char(input int k, input int j);
      int pos;
      pos = (int'(EXT_LEN[k]) > j) ? int'(EXT_LEN[k]) - 1 - j : 0;
      return EXT_NAME[k][pos*8 +: 8];
   endfunction

   // table hit for a one-letter extension
   function automatic ext_mask_type single_hit(input logic [7:0] c);
      ext_mask_type hit;
      hit = '0;
      for (int k = 0; k < EXT_COUNT; k++) begin
         if (EXT_LEN[k] == 4'd1 && EXT_NAME[k][7:0] == c) begin
            hit[k] = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// ----- rtl/core/isaext_match.sv -----
module isaext_match #(
   parameter int NAME_BUFFER_LEN = isaext_pkg::NAME_BUFFER_LEN_DEFAULT
) (
   input  logic [7:0]                 name_chars [NAME_BUFFER_LEN],
   input  logic [7:0]                 name_len,
   output isaext_pkg::ext_mask_type   hit
);

   logic len_ok;

   assign len_ok = (name_len != 8'd0) &&
                   (name_len <= 8'(NAME_BUFFER_LEN)) &&
                   (name_len <= 8'(isaext_pkg::EXT_NAME_MAX));

   // parallel compare against every table entry
   always_comb begin
      logic eq;
      hit = '0;
      for (int k = 0; k < isaext_pkg::EXT_COUNT; k++) begin
         eq = (name_len == 8'(isaext_pkg::EXT_LEN[k]));
         for (int j = 0; j < isaext_pkg::EXT_NAME_MAX; j++) begin
            if (j < int'(isaext_pkg::EXT_LEN[k]) &&
                name_chars[j] != isaext_pkg::ext_char(k, j)) begin
               eq = 1'b0;
            end
         end
         hit[k] = eq & len_ok;
      end
   end

endmodule

// ----- rtl/core/isa_string_extension_parser.sv -----
// the result beat is registered and valid in the cycle after the terminating zero beat is taken
// throughput: one character beat per cycle, set by the combinational parse step between
// the phase register and the result register; a result held on the output stalls input
// reset: synchronous, active high; clears the parser to the start of the prefix, drops
// any pending result and loads width_is_64 = 1 and required_mask = 282311
module isa_string_extension_parser #(
   parameter int NAME_BUFFER_LEN = isaext_pkg::NAME_BUFFER_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // character stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   // parse result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [18:0] ext_mask, [37:19] missing_required, [39:38] status
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [18:0] csr_data
);

   localparam int IDX_W = $clog2(NAME_BUFFER_LEN);

   typedef enum logic [3:0] {
      PH_PREFIX_R,
      PH_PREFIX_V,
      PH_WIDTH_HI,
      PH_WIDTH_LO,
      PH_BASE_I,
      PH_EXT_START,
      PH_SINGLE,
      PH_SINGLE_MAJOR,
      PH_SINGLE_P,
      PH_SINGLE_MINOR,
      PH_S_PENDING,
      PH_MULTI,
      PH_MULTI_P,
      PH_SKIP_X,
      PH_AFTER_SU,
      PH_DRAIN
   } phase_type;

   // parser state
   phase_type                phase_ff, phase_in;
   logic [7:0]               name_buf_ff [NAME_BUFFER_LEN];
   logic [7:0]               tok_len_ff, tok_len_in;
   logic [7:0]               digit_start_ff, digit_start_in;
   logic [7:0]               cut_point_ff, cut_point_in;
   logic [7:0]               prev_char_ff, prev_char_in;
   isaext_pkg::ext_mask_type found_ff, found_in;
   isaext_pkg::status_type   err_ff, err_in;

   // configuration registers
   logic                     width_is_64_ff;
   isaext_pkg::ext_mask_type required_mask_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   isaext_pkg::ext_mask_type rsp_mask_ff, rsp_mask_in;
   isaext_pkg::ext_mask_type rsp_missing_ff, rsp_missing_in;
   isaext_pkg::status_type   rsp_status_ff, rsp_status_in;

   // name buffer writes: slot 0 for a name start, slot n for a name character
   logic                     buf0_we;
   logic [7:0]               buf0_data;
   logic                     bufn_we;
   logic [IDX_W-1:0]         bufn_idx;

   logic                     accept;
   logic [7:0]               c;
   logic                     is_term;
   logic                     legal;
   logic                     match_go;
   isaext_pkg::ext_mask_type name_hit;
   logic [7:0]               w_hi, w_lo;

   // parse step helpers
   logic                     begin_go;
   logic                     multi_go;
   logic [7:0]               m_n;
   logic [7:0]               m_start;
   logic [7:0]               m_cut;
   logic                     m_after_p;

   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign is_term    = (c == isaext_pkg::CH_NUL);
   assign legal      = isaext_pkg::is_lower(c) || isaext_pkg::is_digit(c) ||
                       (c == isaext_pkg::CH_UNDERSCORE);
   // a result waiting on the output holds off the next character until it is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_status_ff, rsp_missing_ff, rsp_mask_ff};

   assign w_hi = width_is_64_ff ? isaext_pkg::CH_6 : isaext_pkg::CH_3;
   assign w_lo = width_is_64_ff ? isaext_pkg::CH_4 : isaext_pkg::CH_2;

   // a multi-letter name closes on underscore or terminator
   assign match_go = (phase_ff == PH_MULTI || phase_ff == PH_MULTI_P) &&
                     (is_term || c == isaext_pkg::CH_UNDERSCORE);

   isaext_match #(
      .NAME_BUFFER_LEN (NAME_BUFFER_LEN)
   ) u_match (
      .name_chars (name_buf_ff),
      .name_len   (cut_point_ff),
      .hit        (name_hit)
   );

   always_comb begin
      phase_in       = phase_ff;
      tok_len_in     = tok_len_ff;
      digit_start_in = digit_start_ff;
      cut_point_in   = cut_point_ff;
      prev_char_in   = prev_char_ff;
      found_in       = found_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_mask_in    = rsp_mask_ff;
      rsp_missing_in = rsp_missing_ff;
      rsp_status_in  = rsp_status_ff;
      buf0_we        = 1'b0;
      buf0_data      = c;
      bufn_we        = 1'b0;
      bufn_idx       = '0;
      begin_go       = 1'b0;
      multi_go       = 1'b0;
      m_n            = tok_len_ff;
      m_start        = digit_start_ff;
      m_cut          = cut_point_ff;
      m_after_p      = (phase_ff == PH_MULTI_P);

      if (accept && is_term) begin
         // terminator: close the open name, emit, restart at the prefix
         rsp_valid_in = 1'b1;
         rsp_status_in = err_ff;
         case (phase_ff) inside
            PH_PREFIX_R, PH_PREFIX_V, PH_WIDTH_HI, PH_WIDTH_LO, PH_BASE_I:
               rsp_status_in = isaext_pkg::STATUS_BAD_PREFIX;
            default: ;
         endcase
         if (rsp_status_in == isaext_pkg::STATUS_OK) begin
            rsp_mask_in = found_ff | (match_go ? name_hit : '0);
         end else begin
            rsp_mask_in = '0;
         end
         rsp_missing_in = required_mask_ff & ~rsp_mask_in;
         phase_in       = PH_PREFIX_R;
         tok_len_in     = '0;
         digit_start_in = '0;
         cut_point_in   = '0;
         prev_char_in   = '0;
         found_in       = '0;
         err_in         = isaext_pkg::STATUS_OK;
      end else if (accept) begin
         prev_char_in = c;
         if (!legal) begin
            err_in   = isaext_pkg::STATUS_ILLEGAL;
            phase_in = PH_DRAIN;
         end else begin
            unique case (phase_ff)
               PH_PREFIX_R: begin
                  if (c == isaext_pkg::CH_R) phase_in = PH_PREFIX_V;
                  else begin
                     err_in   = isaext_pkg::STATUS_BAD_PREFIX;
                     phase_in = PH_DRAIN;
                  end
               end
               PH_PREFIX_V: begin
                  if (c == isaext_pkg::CH_V) phase_in = PH_WIDTH_HI;
                  else begin
                     err_in   = isaext_pkg::STATUS_BAD_PREFIX;
                     phase_in = PH_DRAIN;
                  end
               end
               PH_WIDTH_HI: begin
                  if (c == w_hi) phase_in = PH_WIDTH_LO;
                  else begin
                     err_in   = isaext_pkg::STATUS_BAD_PREFIX;
                     phase_in = PH_DRAIN;
                  end
               end
               PH_WIDTH_LO: begin
                  if (c == w_lo) phase_in = PH_BASE_I;
                  else begin
                     err_in   = isaext_pkg::STATUS_BAD_PREFIX;
                     phase_in = PH_DRAIN;
                  end
               end
               PH_BASE_I: begin
                  if (c == isaext_pkg::CH_I) begin_go = 1'b1;
                  else begin
                     err_in   = isaext_pkg::STATUS_BAD_PREFIX;
                     phase_in = PH_DRAIN;
                  end
               end
               PH_EXT_START, PH_AFTER_SU: begin
                  if (phase_ff == PH_AFTER_SU && c == isaext_pkg::CH_UNDERSCORE)
                     phase_in = PH_EXT_START;
                  else
                     begin_go = 1'b1;
               end
               // a stray p after a version is a one-letter extension with no
               // table entry, so it leaves only the single-letter phase behind
               PH_SINGLE, PH_SINGLE_P: begin
                  if (isaext_pkg::is_digit(c))
                     phase_in = (phase_ff == PH_SINGLE_P) ? PH_SINGLE_MINOR
                                                          : PH_SINGLE_MAJOR;
                  else if (c == isaext_pkg::CH_UNDERSCORE) phase_in = PH_EXT_START;
                  else begin_go = 1'b1;
               end
               PH_SINGLE_MAJOR: begin
                  if (isaext_pkg::is_digit(c)) phase_in = PH_SINGLE_MAJOR;
                  else if (c == isaext_pkg::CH_P) phase_in = PH_SINGLE_P;
                  else if (c == isaext_pkg::CH_UNDERSCORE) phase_in = PH_EXT_START;
                  else begin_go = 1'b1;
               end
               PH_SINGLE_MINOR: begin
                  if (isaext_pkg::is_digit(c)) phase_in = PH_SINGLE_MINOR;
                  else if (c == isaext_pkg::CH_UNDERSCORE) phase_in = PH_EXT_START;
                  else begin_go = 1'b1;
               end
               PH_S_PENDING: begin
                  if (c == isaext_pkg::CH_U) begin
                     // the s-u pair is dropped
                     phase_in = PH_AFTER_SU;
                  end else begin
                     // the held s opens a multi-letter name
                     buf0_we        = 1'b1;
                     buf0_data      = isaext_pkg::CH_S;
                     tok_len_in     = 8'd1;
                     digit_start_in = 8'd1;
                     cut_point_in   = 8'd1;
                     if (c == isaext_pkg::CH_UNDERSCORE) begin
                        // a lone s has no table entry
                        phase_in = PH_EXT_START;
                     end else begin
                        multi_go  = 1'b1;
                        m_n       = 8'd1;
                        m_start   = 8'd1;
                        m_cut     = 8'd1;
                        m_after_p = 1'b0;
                     end
                  end
               end
               PH_MULTI, PH_MULTI_P: begin
                  if (c == isaext_pkg::CH_UNDERSCORE) begin
                     found_in = found_ff | name_hit;
                     phase_in = PH_EXT_START;
                  end else begin
                     multi_go = 1'b1;
                  end
               end
               PH_SKIP_X: begin
                  if (c == isaext_pkg::CH_UNDERSCORE) phase_in = PH_EXT_START;
               end
               PH_DRAIN: ;
               default: ;
            endcase
         end
      end

      // start of an extension
      if (begin_go) begin
         if (c == isaext_pkg::CH_UNDERSCORE || isaext_pkg::is_digit(c)) begin
            err_in   = isaext_pkg::STATUS_ILLEGAL;
            phase_in = PH_DRAIN;
         end else if (c == isaext_pkg::CH_X) begin
            phase_in = PH_SKIP_X;
         end else if (c == isaext_pkg::CH_S &&
                      prev_char_ff != isaext_pkg::CH_UNDERSCORE) begin
            phase_in = PH_S_PENDING;
         end else if (c == isaext_pkg::CH_S || c == isaext_pkg::CH_Z) begin
            buf0_we        = 1'b1;
            tok_len_in     = 8'd1;
            digit_start_in = 8'd1;
            cut_point_in   = 8'd1;
            phase_in       = PH_MULTI;
         end else begin
            found_in = found_ff | isaext_pkg::single_hit(c) |
                       ((c == isaext_pkg::CH_B) ? isaext_pkg::B_EXPAND_MASK : '0);
            phase_in = PH_SINGLE;
         end
      end

      // next character of a multi-letter name, tracking the version suffix
      if (multi_go) begin
         bufn_we  = (m_n < 8'(NAME_BUFFER_LEN));
         bufn_idx = m_n[IDX_W-1:0];
         digit_start_in = m_start;
         cut_point_in   = m_cut;
         phase_in       = PH_MULTI;
         if (isaext_pkg::is_digit(c)) begin
            if (m_after_p) begin
               cut_point_in   = m_start;
               digit_start_in = m_n;
            end else if (!isaext_pkg::is_digit(prev_char_ff)) begin
               digit_start_in = m_n;
               cut_point_in   = m_n;
            end
         end else begin
            cut_point_in = isaext_pkg::sat_inc(m_n);
            if (c == isaext_pkg::CH_P && isaext_pkg::is_digit(prev_char_ff))
               phase_in = PH_MULTI_P;
         end
         tok_len_in = isaext_pkg::sat_inc(m_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_PREFIX_R;
         tok_len_ff       <= '0;
         digit_start_ff   <= '0;
         cut_point_ff     <= '0;
         prev_char_ff     <= '0;
         found_ff         <= '0;
         err_ff           <= isaext_pkg::STATUS_OK;
         rsp_valid_ff     <= 1'b0;
         width_is_64_ff   <= isaext_pkg::WIDTH_IS_64_RESET;
         required_mask_ff <= isaext_pkg::REQUIRED_MASK_RESET;
      end else begin
         phase_ff       <= phase_in;
         tok_len_ff     <= tok_len_in;
         digit_start_ff <= digit_start_in;
         cut_point_ff   <= cut_point_in;
         prev_char_ff   <= prev_char_in;
         found_ff       <= found_in;
         err_ff         <= err_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               isaext_pkg::CSR_WIDTH_IS_64:   width_is_64_ff   <= csr_data[0];
               isaext_pkg::CSR_REQUIRED_MASK: required_mask_ff <= csr_data;
               default: ;
            endcase
         end
      end
      // payload, no reset
      rsp_mask_ff    <= rsp_mask_in;
      rsp_missing_ff <= rsp_missing_in;
      rsp_status_ff  <= rsp_status_in;
      if (buf0_we) name_buf_ff[0] <= buf0_data;
      if (bufn_we) name_buf_ff[bufn_idx] <= c;
   end

endmodule
